@@ sv/sfeg_pkg.sv @@
// ----------------------------------------------------------------------------
// sfeg_pkg
// Shared types and constants for the scheduled fade envelope gain block.
// ----------------------------------------------------------------------------
package sfeg_pkg;

    localparam logic [27:0] LN2_Q28  = 28'd186065280;
    localparam logic [28:0] ONE_Q28  = 29'h1000_0000;
    localparam logic [23:0] GAIN_MAX = 24'hFF_FFFF;
    localparam logic [3:0]  TAYLOR_LAST = 4'd9;
    localparam logic [16:0] DEPTH_FULL  = 17'h1_0000;
    localparam logic [15:0] LIMIT_NONE  = 16'hFFFF;
    localparam int          DIV_STEPS   = 16;

    typedef enum logic [2:0] {
        REG_ATTACK   = 3'd0,
        REG_HOLD     = 3'd1,
        REG_RECOVERY = 3'd2,
        REG_DEPTH    = 3'd3,
        REG_FIRST    = 3'd4,
        REG_PERIOD   = 3'd5,
        REG_WINDOW   = 3'd6,
        REG_LIMIT    = 3'd7
    } reg_index_t;

    typedef enum logic [16:0] {
        ST_IDLE      = 17'h00001,
        ST_RETIRE    = 17'h00002,
        ST_SCHED     = 17'h00004,
        ST_SETUP     = 17'h00008,
        ST_DIV       = 17'h00010,
        ST_RISE_MUL  = 17'h00020,
        ST_RISE_ADD  = 17'h00040,
        ST_EXP_MUL   = 17'h00080,
        ST_EXP_RED   = 17'h00100,
        ST_TAY_MUL   = 17'h00200,
        ST_TAY_RECIP = 17'h00400,
        ST_TAY_QK    = 17'h00800,
        ST_TAY_CORR  = 17'h01000,
        ST_GAIN      = 17'h02000,
        ST_SMP_MUL   = 17'h04000,
        ST_SMP_RND   = 17'h08000,
        ST_OUT       = 17'h10000
    } state_t;

    // Request to the phase divider.
    typedef struct packed {
        logic        start;
        logic [23:0] num;
        logic [23:0] den;
    } div_req_t;

    // Raised-cosine rise, sin^2(pi*k/64) in Q1.16.
    function automatic logic [16:0] rise_lookup(input logic [5:0] idx);
        logic [16:0] v;
        unique case (idx)
            6'd0:  v = 17'd0;     6'd1:  v = 17'd158;   6'd2:  v = 17'd630;
            6'd3:  v = 17'd1411;  6'd4:  v = 17'd2494;  6'd5:  v = 17'd3869;
            6'd6:  v = 17'd5522;  6'd7:  v = 17'd7438;  6'd8:  v = 17'd9598;
            6'd9:  v = 17'd11980; 6'd10: v = 17'd14563; 6'd11: v = 17'd17321;
            6'd12: v = 17'd20228; 6'd13: v = 17'd23256; 6'd14: v = 17'd26375;
            6'd15: v = 17'd29556; 6'd16: v = 17'd32768; 6'd17: v = 17'd35980;
            6'd18: v = 17'd39161; 6'd19: v = 17'd42280; 6'd20: v = 17'd45308;
            6'd21: v = 17'd48215; 6'd22: v = 17'd50973; 6'd23: v = 17'd53556;
            6'd24: v = 17'd55938; 6'd25: v = 17'd58098; 6'd26: v = 17'd60014;
            6'd27: v = 17'd61667; 6'd28: v = 17'd63042; 6'd29: v = 17'd64125;
            6'd30: v = 17'd64906; 6'd31: v = 17'd65378; 6'd32: v = 17'd65536;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // floor(2^32 / k) for the Taylor divisors; divisor one is bypassed.
    function automatic logic [31:0] recip32(input logic [3:0] k);
        logic [31:0] m;
        unique case (k)
            4'd2: m = 32'd2147483648;
            4'd3: m = 32'd1431655765;
            4'd4: m = 32'd1073741824;
            4'd5: m = 32'd858993459;
            4'd6: m = 32'd715827882;
            4'd7: m = 32'd613566756;
            4'd8: m = 32'd536870912;
            4'd9: m = 32'd477218588;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

endpackage

@@ sv/sfeg_div.sv @@
// ----------------------------------------------------------------------------
// sfeg_div
// Restoring divider, one quotient bit per cycle, for the fade phase
// (num << 16) / den with num below den.
// ----------------------------------------------------------------------------
module sfeg_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  sfeg_pkg::div_req_t req,
    output logic              done,
    output logic [15:0]       quot
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [24:0] rem_reg;
    logic [23:0] den_reg;
    logic [15:0] quot_reg;
    logic [25:0] rem_shift;
    logic        fits;

    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = rem_shift >= {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(sfeg_pkg::DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= {1'b0, req.num};
            den_reg  <= req.den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? 25'(rem_shift - {2'b00, den_reg}) : rem_shift[24:0];
            quot_reg <= {quot_reg[14:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ sv/scheduled_fade_envelope_gain_top.sv @@
// ----------------------------------------------------------------------------
// scheduled_fade_envelope_gain_top
// Periodic raised-cosine fades applied to an audio stream; every active fade
// scales the sample by exp(depth_scale * depth) through one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | signals                              | contents
//  ---------+--------------------------------------+---------------------------
//  s_axis   | s_tvalid s_tready s_tdata            | sample_in
//  m_axis   | m_tvalid m_tready m_tdata            | sample_out, fades_active,
//           |                                      | fade_dropped
//  config   | cfg_we cfg_addr cfg_data             | eight setup registers
//
//  Each item passes retirement and scheduling, then for each applied fade
//  the phase divider (in attack or recovery), the ln2 reduction and the
//  Taylor sum. s_tready is high only while the sequencer idles.
//  The finished result waits in an output register, so the next transfer
//  is taken while it stalls. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module scheduled_fade_envelope_gain_top
#(
    parameter int MAX_FADES   = 8,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // sample_in
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // sample_out, fades_active[3:0], fade_dropped
    output logic [((SAMPLE_BITS + 12) / 8) * 8 - 1:0] m_tdata,
    input  logic                                 cfg_we,
    input  logic [2:0]                           cfg_addr,
    input  logic [31:0]                          cfg_data
);

    localparam int IDX_W = (MAX_FADES > 1) ? $clog2(MAX_FADES) : 1;
    localparam int CNT_W = $clog2(MAX_FADES + 1);
    localparam int OUT_W = ((SAMPLE_BITS + 12) / 8) * 8;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX =
        {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN =
        {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // configuration
    logic [23:0]        attack_reg, hold_reg, recovery_reg;
    logic signed [15:0] depth_scale_reg;
    logic [31:0]        period_reg, window_reg;
    logic [15:0]        limit_reg;

    // schedule state
    logic [31:0]        frame_reg;
    logic [31:0]        slot_reg [MAX_FADES];
    logic [CNT_W-1:0]   count_reg;
    logic [31:0]        next_fade_reg;
    logic [15:0]        started_reg;
    logic               sched_done_reg;

    // datapath
    sfeg_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, kept_reg;
    logic               dropped_reg;
    logic signed [SAMPLE_BITS-1:0] smp_reg;
    logic               fall_reg;
    logic [15:0]        phase_reg;
    logic [16:0]        depth_reg;
    logic signed [67:0] prod_reg;
    logic signed [33:0] r_reg;
    logic signed [5:0]  n_reg;
    logic [28:0]        term_reg, t_reg, q_reg;
    logic [29:0]        sum_reg;
    logic [3:0]         k_reg;
    logic [23:0]        gain_reg;

    // output register
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic [3:0]             out_count_reg;
    logic                   out_drop_reg;

    // combinational
    logic [25:0]        span_len;
    logic [24:0]        span_ah;
    logic [31:0]        cur_slot, u_val;
    logic [31:0]        age;
    logic               keep;
    logic               due, sched_end, full;
    logic [32:0]        next_sum;
    sfeg_pkg::div_req_t div_req;
    logic               div_done;
    logic [15:0]        div_q;
    logic [5:0]         rise_idx;
    logic [16:0]        rise_lo, rise_hi, rise_val;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic [28:0]        t_val;
    logic [29:0]        rem_val;
    logic [28:0]        term_new;
    logic signed [6:0]  shift_s;
    logic [30:0]        gain_wide;
    logic signed [67:0] rounded;
    logic signed [SAMPLE_BITS-1:0] smp_sat;
    logic               in_xfer, out_free;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == sfeg_pkg::ST_IDLE);

    assign span_ah  = {1'b0, attack_reg} + {1'b0, hold_reg};
    assign span_len = {1'b0, span_ah} + {2'b00, recovery_reg};
    assign cur_slot = slot_reg[idx_reg[IDX_W-1:0]];
    assign u_val    = frame_reg - cur_slot;
    assign age      = u_val;
    assign keep     = {6'd0, span_len} > age;

    assign due       = !sched_done_reg && (next_fade_reg <= frame_reg);
    assign sched_end = (span_len == 26'd0) || (period_reg == 32'd0) ||
                       (next_fade_reg >= window_reg) ||
                       ((limit_reg != sfeg_pkg::LIMIT_NONE) &&
                        (started_reg >= limit_reg));
    assign full      = ({{(32-CNT_W){1'b0}}, count_reg} >= 32'(MAX_FADES));
    assign next_sum  = {1'b0, next_fade_reg} + {1'b0, period_reg};

    // phase divider request
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = u_val[23:0];
        div_req.den   = attack_reg;
        if (state_reg == sfeg_pkg::ST_SETUP && idx_reg < count_reg)
        begin
            if (u_val < {8'd0, attack_reg})
            begin
                div_req.start = 1'b1;
            end
            else if (u_val >= {7'd0, span_ah} && recovery_reg != 24'd0)
            begin
                div_req.start = 1'b1;
                div_req.num   = 24'(u_val - {7'd0, span_ah});
                div_req.den   = recovery_reg;
            end
        end
    end

    sfeg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_q)
    );

    assign rise_idx = {1'b0, phase_reg[15:11]};
    assign rise_lo  = sfeg_pkg::rise_lookup(rise_idx);
    assign rise_hi  = sfeg_pkg::rise_lookup(6'(rise_idx + 6'd1));
    assign rise_val = 17'(rise_lo + 17'((prod_reg[27:0] + 28'd1024) >> 11));

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            sfeg_pkg::ST_RISE_MUL:
            begin
                mul_a = {17'd0, 17'(rise_hi - rise_lo)};
                mul_b = {23'd0, phase_reg[10:0]};
            end
            sfeg_pkg::ST_EXP_MUL:
            begin
                mul_a = 34'(depth_scale_reg);
                mul_b = {17'd0, depth_reg};
            end
            sfeg_pkg::ST_TAY_MUL:
            begin
                mul_a = {5'd0, term_reg};
                mul_b = r_reg;
            end
            sfeg_pkg::ST_TAY_RECIP:
            begin
                mul_a = {5'd0, t_val};
                mul_b = {2'd0, sfeg_pkg::recip32(k_reg)};
            end
            sfeg_pkg::ST_TAY_QK:
            begin
                mul_a = {5'd0, prod_reg[60:32]};
                mul_b = {30'd0, k_reg};
            end
            sfeg_pkg::ST_SMP_MUL:
            begin
                mul_a = 34'(smp_reg);
                mul_b = {10'd0, gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign t_val    = prod_reg[56:28];
    assign rem_val  = {1'b0, t_reg} - prod_reg[29:0];
    assign term_new = (rem_val >= {26'd0, k_reg}) ? 29'(q_reg + 29'd1) : q_reg;

    // gain = sum * 2^n in Q3.21, rounded half up
    assign shift_s   = 7'sd7 - 7'(n_reg);
    assign gain_wide = ({1'b0, sum_reg} + (31'd1 << (shift_s[4:0] - 5'd1)))
                       >> shift_s[4:0];

    assign rounded = (prod_reg + 68'sd1048576) >>> 21;
    always_comb
    begin
        priority if (rounded > 68'(SMP_MAX))
            smp_sat = SMP_MAX;
        else if (rounded < 68'(SMP_MIN))
            smp_sat = SMP_MIN;
        else
            smp_sat = rounded[SAMPLE_BITS-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfeg_pkg::ST_IDLE:
                if (in_xfer)
                    state_next = sfeg_pkg::ST_RETIRE;
            sfeg_pkg::ST_RETIRE:
                if (idx_reg >= count_reg)
                    state_next = sfeg_pkg::ST_SCHED;
            sfeg_pkg::ST_SCHED:
                state_next = sfeg_pkg::ST_SETUP;
            sfeg_pkg::ST_SETUP:
                priority if (idx_reg >= count_reg)
                    state_next = sfeg_pkg::ST_OUT;
                else if (div_req.start)
                    state_next = sfeg_pkg::ST_DIV;
                else
                    state_next = sfeg_pkg::ST_EXP_MUL;
            sfeg_pkg::ST_DIV:
                if (div_done)
                    state_next = sfeg_pkg::ST_RISE_MUL;
            sfeg_pkg::ST_RISE_MUL:
                state_next = sfeg_pkg::ST_RISE_ADD;
            sfeg_pkg::ST_RISE_ADD:
                state_next = sfeg_pkg::ST_EXP_MUL;
            sfeg_pkg::ST_EXP_MUL:
                state_next = sfeg_pkg::ST_EXP_RED;
            sfeg_pkg::ST_EXP_RED:
                if (r_reg >= 34'sd0 && r_reg < 34'(sfeg_pkg::LN2_Q28))
                    state_next = sfeg_pkg::ST_TAY_MUL;
            sfeg_pkg::ST_TAY_MUL:
                state_next = sfeg_pkg::ST_TAY_RECIP;
            sfeg_pkg::ST_TAY_RECIP:
                state_next = (k_reg == 4'd1) ? sfeg_pkg::ST_TAY_MUL : sfeg_pkg::ST_TAY_QK;
            sfeg_pkg::ST_TAY_QK:
                state_next = sfeg_pkg::ST_TAY_CORR;
            sfeg_pkg::ST_TAY_CORR:
                state_next = (k_reg == sfeg_pkg::TAYLOR_LAST) ? sfeg_pkg::ST_GAIN
                                                              : sfeg_pkg::ST_TAY_MUL;
            sfeg_pkg::ST_GAIN:
                state_next = sfeg_pkg::ST_SMP_MUL;
            sfeg_pkg::ST_SMP_MUL:
                state_next = sfeg_pkg::ST_SMP_RND;
            sfeg_pkg::ST_SMP_RND:
                state_next = sfeg_pkg::ST_SETUP;
            sfeg_pkg::ST_OUT:
                if (out_free)
                    state_next = sfeg_pkg::ST_IDLE;
            default:
                state_next = sfeg_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sfeg_pkg::ST_IDLE;
            attack_reg      <= '0;
            hold_reg        <= '0;
            recovery_reg    <= '0;
            depth_scale_reg <= '0;
            period_reg      <= '0;
            window_reg      <= 32'hFFFF_FFFF;
            limit_reg       <= sfeg_pkg::LIMIT_NONE;
            frame_reg       <= '0;
            count_reg       <= '0;
            next_fade_reg   <= '0;
            started_reg     <= '0;
            sched_done_reg  <= 1'b0;
            idx_reg         <= '0;
            kept_reg        <= '0;
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (sfeg_pkg::reg_index_t'(cfg_addr))
                    sfeg_pkg::REG_ATTACK:   attack_reg      <= cfg_data[23:0];
                    sfeg_pkg::REG_HOLD:     hold_reg        <= cfg_data[23:0];
                    sfeg_pkg::REG_RECOVERY: recovery_reg    <= cfg_data[23:0];
                    sfeg_pkg::REG_DEPTH:    depth_scale_reg <= cfg_data[15:0];
                    sfeg_pkg::REG_FIRST:    next_fade_reg   <= cfg_data;
                    sfeg_pkg::REG_PERIOD:   period_reg      <= cfg_data;
                    sfeg_pkg::REG_WINDOW:   window_reg      <= cfg_data;
                    sfeg_pkg::REG_LIMIT:    limit_reg       <= cfg_data[15:0];
                    default:                limit_reg       <= limit_reg;
                endcase
            end

            // A new result is loaded as the old one leaves or the slot is empty.
            out_valid_reg <= (state_reg == sfeg_pkg::ST_OUT && out_free) ||
                             (out_valid_reg && !m_tready);

            unique case (state_reg)
                sfeg_pkg::ST_IDLE:
                begin
                    idx_reg  <= '0;
                    kept_reg <= '0;
                end
                sfeg_pkg::ST_RETIRE:
                begin
                    if (idx_reg < count_reg)
                    begin
                        idx_reg <= CNT_W'(idx_reg + 1'b1);
                        if (keep)
                            kept_reg <= CNT_W'(kept_reg + 1'b1);
                    end
                    else
                    begin
                        count_reg <= kept_reg;
                    end
                end
                sfeg_pkg::ST_SCHED:
                begin
                    idx_reg <= '0;
                    if (due)
                    begin
                        if (sched_end)
                        begin
                            sched_done_reg <= 1'b1;
                        end
                        else
                        begin
                            if (!full)
                                count_reg <= CNT_W'(count_reg + 1'b1);
                            if (started_reg != 16'hFFFF)
                                started_reg <= started_reg + 16'd1;
                            next_fade_reg <= next_sum[32] ? 32'hFFFF_FFFF : next_sum[31:0];
                        end
                    end
                end
                sfeg_pkg::ST_EXP_MUL:
                    k_reg <= 4'd1;
                sfeg_pkg::ST_TAY_RECIP:
                    if (k_reg == 4'd1)
                        k_reg <= 4'd2;
                sfeg_pkg::ST_TAY_CORR:
                    k_reg <= k_reg + 4'd1;
                sfeg_pkg::ST_SMP_RND:
                    idx_reg <= CNT_W'(idx_reg + 1'b1);
                sfeg_pkg::ST_OUT:
                begin
                    if (out_free)
                        frame_reg <= frame_reg + 32'd1;
                end
                default:
                    k_reg <= k_reg;
            endcase
        end
    end

    // slot store: compaction on retirement, append on a new fade
    always_ff @(posedge clk)
    begin
        if (state_reg == sfeg_pkg::ST_RETIRE && idx_reg < count_reg && keep)
            slot_reg[kept_reg[IDX_W-1:0]] <= cur_slot;
        else if (state_reg == sfeg_pkg::ST_SCHED && due && !sched_end && !full)
            slot_reg[count_reg[IDX_W-1:0]] <= frame_reg;
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            sfeg_pkg::ST_IDLE:
            begin
                smp_reg     <= s_tdata[SAMPLE_BITS-1:0];
                dropped_reg <= 1'b0;
            end
            sfeg_pkg::ST_SCHED:
                dropped_reg <= due && !sched_end && full;
            sfeg_pkg::ST_SETUP:
            begin
                fall_reg  <= !(u_val < {8'd0, attack_reg});
                depth_reg <= sfeg_pkg::DEPTH_FULL;
            end
            sfeg_pkg::ST_DIV:
                phase_reg <= div_q;
            sfeg_pkg::ST_RISE_MUL:
                prod_reg <= mul_p;
            sfeg_pkg::ST_RISE_ADD:
                depth_reg <= fall_reg ? 17'(sfeg_pkg::DEPTH_FULL - rise_val) : rise_val;
            sfeg_pkg::ST_EXP_MUL:
            begin
                r_reg    <= mul_p[33:0];
                n_reg    <= '0;
                term_reg <= sfeg_pkg::ONE_Q28;
                sum_reg  <= {1'b0, sfeg_pkg::ONE_Q28};
            end
            sfeg_pkg::ST_EXP_RED:
            begin
                if (r_reg < 34'sd0)
                begin
                    r_reg <= r_reg + 34'(sfeg_pkg::LN2_Q28);
                    n_reg <= n_reg - 6'sd1;
                end
                else if (r_reg >= 34'(sfeg_pkg::LN2_Q28))
                begin
                    r_reg <= r_reg - 34'(sfeg_pkg::LN2_Q28);
                    n_reg <= n_reg + 6'sd1;
                end
            end
            sfeg_pkg::ST_TAY_MUL:
                prod_reg <= mul_p;
            sfeg_pkg::ST_TAY_RECIP:
            begin
                t_reg <= t_val;
                if (k_reg == 4'd1)
                begin
                    term_reg <= t_val;
                    sum_reg  <= sum_reg + {1'b0, t_val};
                end
                else
                begin
                    prod_reg <= mul_p;
                end
            end
            sfeg_pkg::ST_TAY_QK:
            begin
                q_reg    <= prod_reg[60:32];
                prod_reg <= mul_p;
            end
            sfeg_pkg::ST_TAY_CORR:
            begin
                term_reg <= term_new;
                sum_reg  <= sum_reg + {1'b0, term_new};
            end
            sfeg_pkg::ST_GAIN:
            begin
                if (shift_s <= 7'sd0 || gain_wide > {7'd0, sfeg_pkg::GAIN_MAX})
                    gain_reg <= sfeg_pkg::GAIN_MAX;
                else
                    gain_reg <= gain_wide[23:0];
            end
            sfeg_pkg::ST_SMP_MUL:
                prod_reg <= mul_p;
            sfeg_pkg::ST_SMP_RND:
                smp_reg <= smp_sat;
            sfeg_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_sample_reg <= smp_reg;
                    out_count_reg  <= 4'(count_reg);
                    out_drop_reg   <= dropped_reg;
                end
            end
            default:
                gain_reg <= gain_reg;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_drop_reg, out_count_reg, out_sample_reg});

endmodule

@@ sv/sfeg_checker.sv @@
// ----------------------------------------------------------------------------
// sfeg_checker
// Port-level checks for the scheduled fade envelope gain block.
// ----------------------------------------------------------------------------
module sfeg_checker
#(
    parameter int MAX_FADES   = 8,
    parameter int SAMPLE_BITS = 24
)
(
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    s_tvalid,
    input logic                                    s_tready,
    input logic                                    m_tvalid,
    input logic                                    m_tready,
    input logic [((SAMPLE_BITS + 12) / 8) * 8 - 1:0] m_tdata
);

    logic [3:0] fades_active;
    logic       fade_dropped;

    assign fades_active = m_tdata[SAMPLE_BITS+3:SAMPLE_BITS];
    assign fade_dropped = m_tdata[SAMPLE_BITS+4];

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The block works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while busy");

    // Never more fades than slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && MAX_FADES < 16 |-> fades_active <= 4'(MAX_FADES))
        else $error("fade count above slot count");

    // A fade is dropped only when every slot is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && fade_dropped |-> fades_active == 4'(MAX_FADES))
        else $error("fade dropped with a free slot");

endmodule

bind scheduled_fade_envelope_gain_top sfeg_checker
#(
    .MAX_FADES   (MAX_FADES),
    .SAMPLE_BITS (SAMPLE_BITS)
)
u_sfeg_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/scheduled_fade_envelope_gain_top_test.sv @@
// ----------------------------------------------------------------------------
// scheduled_fade_envelope_gain_top_test
// Streams audio samples through the fade block under several schedules and
// envelope settings, predicts each output transfer with a bit-exact model of
// the fade arithmetic or a listed value, and compares the results field by field,
// with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scheduled_fade_envelope_gain_top_test;

    localparam int  NUM_SLOTS  = 8;
    localparam int  CYCLE_CAP  = 4000000;
    localparam int  SETTLE     = 700;

    typedef struct packed {
        logic [23:0] sample;
        logic [3:0]  fades;
        logic        dropped;
    } fade_result_t;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        sfeg_pkg::reg_index_t addr;
        logic [31:0]          value;
        bit                   typed;
        fade_result_t         want;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;
    logic                 cfg_we;
    sfeg_pkg::reg_index_t cfg_addr;
    logic [31:0]          cfg_data;

    // Shadow copy of the block's registers and schedule state.
    logic [23:0]        attack_len, hold_len, recovery_len;
    logic signed [15:0] depth_q12;
    logic [31:0]        period_len, window_end;
    logic [15:0]        limit_count;
    logic [31:0]        frame_no;
    logic [31:0]        slot_start [NUM_SLOTS];
    int                 slots_used;
    logic [31:0]        next_due;
    logic [15:0]        started_count;
    bit                 schedule_over;

    fade_result_t pending_results [$];
    int           mismatches;
    int           send_gap_pct;
    int           stall_pct;

    scheduled_fade_envelope_gain_top i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_CAP) @(posedge clk);
        $display("scheduled_fade_envelope_gain_top test failed");
        $finish;
    end

    function automatic logic [16:0] cos_rise(input longint unsigned x);
        logic [16:0] lo, hi;
        longint unsigned frac;
        lo   = sfeg_pkg::rise_lookup(6'((x >> 11) & 31));
        hi   = sfeg_pkg::rise_lookup(6'(((x >> 11) & 31) + 1));
        frac = x & 2047;
        return lo + 17'(((longint'(hi - lo) * frac) + 1024) >> 11);
    endfunction

    function automatic logic [23:0] fade_gain(input longint x);
        longint            ln2, n, r, s;
        longint unsigned   term, total, g;
        ln2 = longint'(sfeg_pkg::LN2_Q28);
        if (x >= 0)
            n = x / ln2;
        else
            n = -((-x + ln2 - 1) / ln2);
        r     = x - n * ln2;
        term  = 64'd1 << 28;
        total = term;
        for (int k = 1; k <= 9; k++)
        begin
            term  = ((term * longint'(r)) >> 28) / k;
            total = total + term;
        end
        s = 7 - n;
        if (s <= 0)
            return sfeg_pkg::GAIN_MAX;
        if (s > 40)
            return 24'd0;
        g = (total + (64'd1 << (s - 1))) >> s;
        return (g > 64'hFF_FFFF) ? sfeg_pkg::GAIN_MAX : g[23:0];
    endfunction

    function automatic fade_result_t apply_fades(input logic [23:0] raw);
        fade_result_t      res;
        longint unsigned   span, ah, u;
        longint            smp, prod;
        logic [31:0]       age;
        logic [16:0]       depth;
        longint unsigned   nx;
        int                kept;
        span = longint'(attack_len) + hold_len + recovery_len;
        ah   = longint'(attack_len) + hold_len;
        smp  = longint'($signed(raw));
        res.dropped = 1'b0;
        kept = 0;
        for (int i = 0; i < slots_used; i++)
        begin
            age = frame_no - slot_start[i];
            if (longint'(age) < span)
            begin
                slot_start[kept] = slot_start[i];
                kept++;
            end
        end
        slots_used = kept;
        if (!schedule_over && next_due <= frame_no)
        begin
            if (span == 0 || period_len == 0 || next_due >= window_end ||
                (limit_count != sfeg_pkg::LIMIT_NONE && started_count >= limit_count))
                schedule_over = 1'b1;
            else
            begin
                nx = longint'(next_due) + period_len;
                if (slots_used < NUM_SLOTS)
                begin
                    slot_start[slots_used] = frame_no;
                    slots_used++;
                end
                else
                    res.dropped = 1'b1;
                if (started_count != 16'hFFFF)
                    started_count++;
                next_due = (nx > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nx[31:0];
            end
        end
        for (int i = 0; i < slots_used; i++)
        begin
            u     = longint'(frame_no - slot_start[i]);
            depth = sfeg_pkg::DEPTH_FULL;
            if (u < attack_len)
                depth = cos_rise((u << 16) / attack_len);
            else if (u >= ah && recovery_len != 0)
                depth = sfeg_pkg::DEPTH_FULL - cos_rise(((u - ah) << 16) / recovery_len);
            prod = smp * longint'(fade_gain(longint'(depth_q12) * longint'(depth)));
            smp  = (prod + (64'sd1 <<< 20)) >>> 21;
            if (smp > 64'sd8388607)
                smp = 64'sd8388607;
            else if (smp < -64'sd8388608)
                smp = -64'sd8388608;
        end
        res.sample = smp[23:0];
        res.fades  = 4'(slots_used);
        frame_no   = frame_no + 1;
        return res;
    endfunction

    task automatic write_reg(input sfeg_pkg::reg_index_t addr, input logic [31:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        case (addr)
            sfeg_pkg::REG_ATTACK:   attack_len   = value[23:0];
            sfeg_pkg::REG_HOLD:     hold_len     = value[23:0];
            sfeg_pkg::REG_RECOVERY: recovery_len = value[23:0];
            sfeg_pkg::REG_DEPTH:    depth_q12    = value[15:0];
            sfeg_pkg::REG_FIRST:    next_due     = value;
            sfeg_pkg::REG_PERIOD:   period_len   = value;
            sfeg_pkg::REG_WINDOW:   window_end   = value;
            sfeg_pkg::REG_LIMIT:    limit_count  = value[15:0];
            default: ;
        endcase
    endtask

    // Drops the input valid and waits until every outstanding result is back.
    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_sample(input logic [23:0] smp, input bit typed,
                               input fade_result_t want);
        fade_result_t got_pred;
        @(negedge clk);
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do
            @(posedge clk);
        while (!s_tready);
        got_pred = apply_fades(smp);
        pending_results.push_back(typed ? want : got_pred);
    endtask

    // Output side: random stalls set at the falling edge, checks at the rising.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        fade_result_t got, want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = {m_tdata[23:0], m_tdata[27:24], m_tdata[28]};
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output transfer %h", m_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: sample %h/%h fades %0d/%0d dropped %b/%b",
                                     want.sample, got.sample, want.fades, got.fades,
                                     want.dropped, got.dropped);
                    end
                end
            end
        end
    end

    initial
    begin
        row_t         rows [$];
        row_t         r;
        fade_result_t none;
        logic [23:0]  a, h, rc;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_addr     = sfeg_pkg::REG_ATTACK;
        cfg_data     = '0;
        mismatches   = 0;
        send_gap_pct = 0;
        stall_pct    = 0;

        attack_len = '0; hold_len = '0; recovery_len = '0; depth_q12 = '0;
        period_len = '0; window_end = 32'hFFFF_FFFF;
        limit_count = sfeg_pkg::LIMIT_NONE; frame_no = '0; slots_used = 0;
        next_due = '0; started_count = '0; schedule_over = 1'b0;
        foreach (slot_start[i])
            slot_start[i] = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        none = '0;
        // A due event under zero spans would close the schedule for good, so the
        // first event is pushed out while the reset settings pass samples unchanged.
        rows.push_back('{ROW_WRITE, sfeg_pkg::REG_FIRST, 32'd100, 0, none});
        rows.push_back('{ROW_SAMPLE, sfeg_pkg::REG_ATTACK, 32'h7F_FFFF, 1,
                         '{24'h7F_FFFF, 4'd0, 1'b0}});
        rows.push_back('{ROW_SAMPLE, sfeg_pkg::REG_ATTACK, 32'h80_0000, 1,
                         '{24'h80_0000, 4'd0, 1'b0}});
        rows.push_back('{ROW_SAMPLE, sfeg_pkg::REG_ATTACK, 32'h00_0000, 1,
                         '{24'h00_0000, 4'd0, 1'b0}});
        rows.push_back('{ROW_SAMPLE, sfeg_pkg::REG_ATTACK, 32'hFF_FFFF, 1,
                         '{24'hFF_FFFF, 4'd0, 1'b0}});
        // Rectangular fade at the deepest cut, started from a frame already past.
        rows.push_back('{ROW_WRITE, sfeg_pkg::REG_ATTACK,   32'd0,     0, none});
        rows.push_back('{ROW_WRITE, sfeg_pkg::REG_HOLD,     32'd3,     0, none});
        rows.push_back('{ROW_WRITE, sfeg_pkg::REG_RECOVERY, 32'd0,     0, none});
        rows.push_back('{ROW_WRITE, sfeg_pkg::REG_DEPTH,    32'h8000,  0, none});
        rows.push_back('{ROW_WRITE, sfeg_pkg::REG_PERIOD,   32'd1,     0, none});
        rows.push_back('{ROW_WRITE, sfeg_pkg::REG_FIRST,    32'd0,     0, none});
        rows.push_back('{ROW_SAMPLE, sfeg_pkg::REG_ATTACK, 32'h7F_FFFF, 0, none});
        rows.push_back('{ROW_SAMPLE, sfeg_pkg::REG_ATTACK, 32'h7F_FFFF, 0, none});
        rows.push_back('{ROW_SAMPLE, sfeg_pkg::REG_ATTACK, 32'h80_0000, 0, none});
        rows.push_back('{ROW_SAMPLE, sfeg_pkg::REG_ATTACK, 32'h00_0001, 0, none});
        // Largest boost: the gain saturates and so does the sample.
        rows.push_back('{ROW_WRITE, sfeg_pkg::REG_DEPTH,    32'h7FFF,  0, none});
        rows.push_back('{ROW_SAMPLE, sfeg_pkg::REG_ATTACK, 32'h00_0001, 0, none});
        rows.push_back('{ROW_SAMPLE, sfeg_pkg::REG_ATTACK, 32'h7F_FFFF, 0, none});
        rows.push_back('{ROW_SAMPLE, sfeg_pkg::REG_ATTACK, 32'h80_0000, 0, none});
        // Long hold with a fade every frame fills all slots and drops the rest.
        rows.push_back('{ROW_WRITE, sfeg_pkg::REG_HOLD,     32'd20,    0, none});
        for (int i = 0; i < 10; i++)
            rows.push_back('{ROW_SAMPLE, sfeg_pkg::REG_ATTACK, 32'(24'h40_0000 + i), 0, none});

        foreach (rows[i])
        begin
            r = rows[i];
            if (r.kind == ROW_WRITE)
            begin
                drain();
                write_reg(r.addr, r.value);
            end
            else
                send_sample(r.value[23:0], r.typed, r.want);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            send_gap_pct = (ph % 4 == 1) ? 52 : ((ph % 4 == 3) ? 36 : 0);
            stall_pct    = (ph % 4 == 2) ? 52 : ((ph % 4 == 3) ? 36 : 0);
            if (ph == 0)
            begin
                a = 24'hFF_FFFF; h = 24'hFF_FFFF; rc = 24'hFF_FFFF;
            end
            else
            begin
                a  = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(1, 48));
                h  = 24'($urandom_range(0, 20));
                rc = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(1, 48));
                if (a + h + rc == 0)
                    h = 24'd1;
            end
            write_reg(sfeg_pkg::REG_ATTACK, a);
            write_reg(sfeg_pkg::REG_HOLD, h);
            write_reg(sfeg_pkg::REG_RECOVERY, rc);
            write_reg(sfeg_pkg::REG_DEPTH,
                      (ph == 0) ? 32'h7FFF : 32'($urandom_range(0, 65535)));
            write_reg(sfeg_pkg::REG_WINDOW, (ph == 7) ? 32'd0 : 32'hFFFF_FFFF);
            case (ph)
                6:       write_reg(sfeg_pkg::REG_LIMIT, 32'(started_count + 5));
                7:       write_reg(sfeg_pkg::REG_LIMIT, 32'd0);
                default: write_reg(sfeg_pkg::REG_LIMIT, 32'(sfeg_pkg::LIMIT_NONE));
            endcase
            if (ph == 3)
            begin
                // Nothing falls due: the running fades just age out.
                write_reg(sfeg_pkg::REG_PERIOD, 32'hFFFF_FFFF);
                write_reg(sfeg_pkg::REG_FIRST, 32'hFFFF_FFFF);
            end
            else
            begin
                write_reg(sfeg_pkg::REG_PERIOD,
                          (ph == 0) ? 32'd5 : 32'($urandom_range(1, 24)));
                write_reg(sfeg_pkg::REG_FIRST, $urandom_range(0, 1) ? 32'd0
                                     : frame_no + $urandom_range(0, 10));
            end
            for (int i = 0; i < 100; i++)
                send_sample(24'($urandom()), 1'b0, none);
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("scheduled_fade_envelope_gain_top test passed");
        else
            $display("scheduled_fade_envelope_gain_top test failed");
        $finish;
    end

endmodule
